/* rtl/nearest_ray_triangle_hit_unit_macros.svh */
// ----------------------------------------------------------------------------
// nearest ray triangle hit unit assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef NEAREST_RAY_TRIANGLE_HIT_UNIT_MACROS_SVH
`define NEAREST_RAY_TRIANGLE_HIT_UNIT_MACROS_SVH

// same-cycle implication
`define NRTH_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NRTH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/nrth_pkg.sv */
// ----------------------------------------------------------------------------
// nrth_pkg
// widths, codes, queue payload types and the multiply sequence table
// ----------------------------------------------------------------------------
package nrth_pkg;

    localparam int VTX_W     = 32;
    localparam int D_W       = 18;
    localparam int E_W       = 33;
    localparam int H_W       = 52;
    localparam int Q_W       = 67;
    localparam int DOT_W     = 87;
    localparam int TN_W      = 102;
    localparam int ACC_W     = 104;
    localparam int AB_W      = 88;
    localparam int ST_W      = 103;
    localparam int TS_W      = 119;
    localparam int CMP_W     = 120;
    localparam int DIST_W    = 31;
    localparam int IDX_W     = 16;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int MUL_STEPS = 33;
    localparam int NUM_OPS   = 24;
    localparam int DIV_STEPS = 31;

    localparam int DEF_MAX_TRIANGLES = 65536;
    localparam int DEF_TRI_DEPTH     = 2;
    localparam int DEF_RES_DEPTH     = 2;

    localparam int DET_EPS = 28147497;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 3'd5;
    localparam logic [D_W-1:0] DIR_Z_RESET = 18'h30000;

    // wide multiplicand select
    localparam logic [3:0] A_E2X = 4'd0;
    localparam logic [3:0] A_E2Y = 4'd1;
    localparam logic [3:0] A_E2Z = 4'd2;
    localparam logic [3:0] A_SX  = 4'd3;
    localparam logic [3:0] A_SY  = 4'd4;
    localparam logic [3:0] A_SZ  = 4'd5;
    localparam logic [3:0] A_HX  = 4'd6;
    localparam logic [3:0] A_HY  = 4'd7;
    localparam logic [3:0] A_HZ  = 4'd8;
    localparam logic [3:0] A_QX  = 4'd9;
    localparam logic [3:0] A_QY  = 4'd10;
    localparam logic [3:0] A_QZ  = 4'd11;

    // serial multiplier select
    localparam logic [3:0] B_DX  = 4'd0;
    localparam logic [3:0] B_DY  = 4'd1;
    localparam logic [3:0] B_DZ  = 4'd2;
    localparam logic [3:0] B_E1X = 4'd3;
    localparam logic [3:0] B_E1Y = 4'd4;
    localparam logic [3:0] B_E1Z = 4'd5;
    localparam logic [3:0] B_SX  = 4'd6;
    localparam logic [3:0] B_SY  = 4'd7;
    localparam logic [3:0] B_SZ  = 4'd8;
    localparam logic [3:0] B_E2X = 4'd9;
    localparam logic [3:0] B_E2Y = 4'd10;
    localparam logic [3:0] B_E2Z = 4'd11;

    // product destination
    localparam logic [3:0] DST_H0 = 4'd0;
    localparam logic [3:0] DST_H1 = 4'd1;
    localparam logic [3:0] DST_H2 = 4'd2;
    localparam logic [3:0] DST_Q0 = 4'd3;
    localparam logic [3:0] DST_Q1 = 4'd4;
    localparam logic [3:0] DST_Q2 = 4'd5;
    localparam logic [3:0] DST_A  = 4'd6;
    localparam logic [3:0] DST_UN = 4'd7;
    localparam logic [3:0] DST_VN = 4'd8;
    localparam logic [3:0] DST_TN = 4'd9;

    typedef struct packed {
        logic [3:0] asel;
        logic [3:0] bsel;
        logic       sub;
        logic       first;
        logic [3:0] dst;
    } op_ctrl_t;

    typedef struct packed {
        logic [2:0][E_W-1:0] e1;
        logic [2:0][E_W-1:0] e2;
        logic [2:0][E_W-1:0] s;
        logic                last;
    } tri_t;

    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] distance;
        logic [IDX_W-1:0]  idx;
    } result_t;

    // h = d x e2, q = s x e1, then a, un, vn, tn as dot products
    function automatic op_ctrl_t op_entry(input logic [4:0] idx);
        op_ctrl_t c;
        case (idx)
            5'd0:    c = '{A_E2Z, B_DY,  1'b0, 1'b1, DST_H0};
            5'd1:    c = '{A_E2Y, B_DZ,  1'b1, 1'b0, DST_H0};
            5'd2:    c = '{A_E2X, B_DZ,  1'b0, 1'b1, DST_H1};
            5'd3:    c = '{A_E2Z, B_DX,  1'b1, 1'b0, DST_H1};
            5'd4:    c = '{A_E2Y, B_DX,  1'b0, 1'b1, DST_H2};
            5'd5:    c = '{A_E2X, B_DY,  1'b1, 1'b0, DST_H2};
            5'd6:    c = '{A_SY,  B_E1Z, 1'b0, 1'b1, DST_Q0};
            5'd7:    c = '{A_SZ,  B_E1Y, 1'b1, 1'b0, DST_Q0};
            5'd8:    c = '{A_SZ,  B_E1X, 1'b0, 1'b1, DST_Q1};
            5'd9:    c = '{A_SX,  B_E1Z, 1'b1, 1'b0, DST_Q1};
            5'd10:   c = '{A_SX,  B_E1Y, 1'b0, 1'b1, DST_Q2};
            5'd11:   c = '{A_SY,  B_E1X, 1'b1, 1'b0, DST_Q2};
            5'd12:   c = '{A_HX,  B_E1X, 1'b0, 1'b1, DST_A};
            5'd13:   c = '{A_HY,  B_E1Y, 1'b0, 1'b0, DST_A};
            5'd14:   c = '{A_HZ,  B_E1Z, 1'b0, 1'b0, DST_A};
            5'd15:   c = '{A_HX,  B_SX,  1'b0, 1'b1, DST_UN};
            5'd16:   c = '{A_HY,  B_SY,  1'b0, 1'b0, DST_UN};
            5'd17:   c = '{A_HZ,  B_SZ,  1'b0, 1'b0, DST_UN};
            5'd18:   c = '{A_QX,  B_DX,  1'b0, 1'b1, DST_VN};
            5'd19:   c = '{A_QY,  B_DY,  1'b0, 1'b0, DST_VN};
            5'd20:   c = '{A_QZ,  B_DZ,  1'b0, 1'b0, DST_VN};
            5'd21:   c = '{A_QX,  B_E2X, 1'b0, 1'b1, DST_TN};
            5'd22:   c = '{A_QY,  B_E2Y, 1'b0, 1'b0, DST_TN};
            default: c = '{A_QZ,  B_E2Z, 1'b0, 1'b0, DST_TN};
        endcase
        return c;
    endfunction

endpackage

/* rtl/nrth_queue.sv */
// ----------------------------------------------------------------------------
// nrth_queue
// small first-in first-out queue with push/full and pop/empty sides
// ----------------------------------------------------------------------------
module nrth_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* rtl/nrth_front.sv */
// ----------------------------------------------------------------------------
// nrth_front
// takes triangles, forms edges and origin offset, queues them for the back
// ----------------------------------------------------------------------------
module nrth_front
    import nrth_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_TRI_DEPTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic signed [VTX_W-1:0] v0_x,
    input  logic signed [VTX_W-1:0] v0_y,
    input  logic signed [VTX_W-1:0] v0_z,
    input  logic signed [VTX_W-1:0] v1_x,
    input  logic signed [VTX_W-1:0] v1_y,
    input  logic signed [VTX_W-1:0] v1_z,
    input  logic signed [VTX_W-1:0] v2_x,
    input  logic signed [VTX_W-1:0] v2_y,
    input  logic signed [VTX_W-1:0] v2_z,
    input  logic                    last_triangle,
    input  logic signed [VTX_W-1:0] origin_x,
    input  logic signed [VTX_W-1:0] origin_y,
    input  logic signed [VTX_W-1:0] origin_z,
    input  logic                    tri_pop,
    output logic                    tri_empty,
    output tri_t                    tri_data
);

    tri_t tri_in;
    logic [$bits(tri_t)-1:0] tri_rdata;

    always_comb
    begin
        tri_in.e1[0] = E_W'(v1_x) - E_W'(v0_x);
        tri_in.e1[1] = E_W'(v1_y) - E_W'(v0_y);
        tri_in.e1[2] = E_W'(v1_z) - E_W'(v0_z);
        tri_in.e2[0] = E_W'(v2_x) - E_W'(v0_x);
        tri_in.e2[1] = E_W'(v2_y) - E_W'(v0_y);
        tri_in.e2[2] = E_W'(v2_z) - E_W'(v0_z);
        tri_in.s[0]  = E_W'(origin_x) - E_W'(v0_x);
        tri_in.s[1]  = E_W'(origin_y) - E_W'(v0_y);
        tri_in.s[2]  = E_W'(origin_z) - E_W'(v0_z);
        tri_in.last  = last_triangle;
    end

    nrth_queue #(
        .WIDTH ($bits(tri_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_tri_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (tri_in),
        .full  (full),
        .pop   (tri_pop),
        .rdata (tri_rdata),
        .empty (tri_empty)
    );

    assign tri_data = tri_t'(tri_rdata);

endmodule

/* rtl/nrth_back.sv */
// ----------------------------------------------------------------------------
// nrth_back
// serial multiply-accumulate sequencer, hit tests, divider and nearest hit
// ----------------------------------------------------------------------------
module nrth_back
    import nrth_pkg::*;
#(
    parameter int MAX_TRIANGLES = DEF_MAX_TRIANGLES
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic signed [D_W-1:0] dir_x,
    input  logic signed [D_W-1:0] dir_y,
    input  logic signed [D_W-1:0] dir_z,
    input  logic                  tri_empty,
    input  tri_t                  tri_data,
    output logic                  tri_pop,
    input  logic                  res_full,
    output logic                  res_push,
    output result_t               res_data
);

    localparam int CNT_W = $clog2(MAX_TRIANGLES);
    localparam logic [CNT_W:0] CNT_LIMIT = (CNT_W + 1)'(MAX_TRIANGLES);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_NEG  = 3'd3;
    localparam logic [2:0] ST_TEST = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_UPD  = 3'd6;
    localparam logic [2:0] ST_EMIT = 3'd7;

    // control
    logic [2:0]        state_reg, state_next;
    logic [4:0]        op_reg, op_next;
    logic [5:0]        bit_reg, bit_next;
    logic [4:0]        div_reg, div_next;
    logic              seen_reg, seen_next;
    logic [DIST_W-1:0] best_dist_reg, best_dist_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    // datapath
    tri_t                     tri_reg, tri_next;
    logic [ACC_W-1:0]         a_sh_reg, a_sh_next;
    logic [E_W-1:0]           b_sh_reg, b_sh_next;
    logic [ACC_W-1:0]         acc_reg, acc_next;
    logic [2:0][H_W-1:0]      h_reg, h_next;
    logic [2:0][Q_W-1:0]      q_reg, q_next;
    logic [DOT_W-1:0]         a_reg, a_next;
    logic [DOT_W-1:0]         un_reg, un_next;
    logic [DOT_W-1:0]         vn_reg, vn_next;
    logic [TN_W-1:0]          tn_reg, tn_next;
    logic signed [AB_W-1:0]   absa_reg, absa_next;
    logic signed [AB_W-1:0]   sun_reg, sun_next;
    logic signed [AB_W-1:0]   svn_reg, svn_next;
    logic signed [ST_W-1:0]   stn_reg, stn_next;
    logic [TS_W-1:0]          rem_reg, rem_next;
    logic [TS_W-1:0]          den_reg, den_next;
    logic [DIST_W-1:0]        quot_reg, quot_next;
    logic                     hit_reg, hit_next;
    logic [DIST_W-1:0]        t_reg, t_next;

    op_ctrl_t                 op_c;
    logic [ACC_W-1:0]         a_mux;
    logic [E_W-1:0]           b_mux;
    logic [ACC_W-1:0]         mul_term;
    logic                     mul_sub;
    logic [ACC_W-1:0]         acc_sum;
    logic signed [CMP_W-1:0]  c_abs, c_un, c_vn, c_uv, c_ts, c_lim, c_eps;
    logic                     miss;
    logic                     sat;
    logic                     div_ge;
    logic [DIST_W-1:0]        quot_sh;
    logic [CNT_W:0]           cnt_inc;

    always_comb
    begin
        op_c = op_entry(op_reg);
        case (op_c.asel)
            A_E2X:   a_mux = ACC_W'($signed(tri_reg.e2[0]));
            A_E2Y:   a_mux = ACC_W'($signed(tri_reg.e2[1]));
            A_E2Z:   a_mux = ACC_W'($signed(tri_reg.e2[2]));
            A_SX:    a_mux = ACC_W'($signed(tri_reg.s[0]));
            A_SY:    a_mux = ACC_W'($signed(tri_reg.s[1]));
            A_SZ:    a_mux = ACC_W'($signed(tri_reg.s[2]));
            A_HX:    a_mux = ACC_W'($signed(h_reg[0]));
            A_HY:    a_mux = ACC_W'($signed(h_reg[1]));
            A_HZ:    a_mux = ACC_W'($signed(h_reg[2]));
            A_QX:    a_mux = ACC_W'($signed(q_reg[0]));
            A_QY:    a_mux = ACC_W'($signed(q_reg[1]));
            A_QZ:    a_mux = ACC_W'($signed(q_reg[2]));
            default: a_mux = '0;
        endcase
        case (op_c.bsel)
            B_DX:    b_mux = E_W'(dir_x);
            B_DY:    b_mux = E_W'(dir_y);
            B_DZ:    b_mux = E_W'(dir_z);
            B_E1X:   b_mux = tri_reg.e1[0];
            B_E1Y:   b_mux = tri_reg.e1[1];
            B_E1Z:   b_mux = tri_reg.e1[2];
            B_SX:    b_mux = tri_reg.s[0];
            B_SY:    b_mux = tri_reg.s[1];
            B_SZ:    b_mux = tri_reg.s[2];
            B_E2X:   b_mux = tri_reg.e2[0];
            B_E2Y:   b_mux = tri_reg.e2[1];
            B_E2Z:   b_mux = tri_reg.e2[2];
            default: b_mux = '0;
        endcase

        // the top multiplier bit carries negative weight
        mul_term = b_sh_reg[0] ? a_sh_reg : '0;
        mul_sub  = (bit_reg == 6'(MUL_STEPS - 1)) ^ op_c.sub;
        acc_sum  = mul_sub ? acc_reg - mul_term : acc_reg + mul_term;

        c_abs = CMP_W'(absa_reg);
        c_un  = CMP_W'(sun_reg);
        c_vn  = CMP_W'(svn_reg);
        c_uv  = c_un + c_vn;
        c_ts  = CMP_W'(stn_reg) << 16;
        c_lim = c_abs << DIST_W;
        c_eps = CMP_W'(DET_EPS);
        miss  = (c_abs <= c_eps) || c_un[CMP_W-1] || (c_un > c_abs) || c_vn[CMP_W-1]
                || (c_uv > c_abs) || (c_ts <= c_abs);
        sat   = (c_ts >= c_lim);

        div_ge  = (rem_reg >= den_reg);
        quot_sh = {quot_reg[DIST_W-2:0], div_ge};
        cnt_inc = (CNT_W + 1)'(cnt_reg) + 1'b1;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        bit_next       = bit_reg;
        div_next       = div_reg;
        seen_next      = seen_reg;
        best_dist_next = best_dist_reg;
        best_idx_next  = best_idx_reg;
        cnt_next       = cnt_reg;
        tri_next       = tri_reg;
        a_sh_next      = a_sh_reg;
        b_sh_next      = b_sh_reg;
        acc_next       = acc_reg;
        h_next         = h_reg;
        q_next         = q_reg;
        a_next         = a_reg;
        un_next        = un_reg;
        vn_next        = vn_reg;
        tn_next        = tn_reg;
        absa_next      = absa_reg;
        sun_next       = sun_reg;
        svn_next       = svn_reg;
        stn_next       = stn_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        quot_next      = quot_reg;
        hit_next       = hit_reg;
        t_next         = t_reg;
        tri_pop        = 1'b0;
        res_push       = 1'b0;
        res_data       = '{seen_reg, best_dist_reg, best_idx_reg};

        case (state_reg)
            ST_IDLE:
            begin
                if (!tri_empty)
                begin
                    tri_pop    = 1'b1;
                    tri_next   = tri_data;
                    op_next    = '0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                a_sh_next = a_mux;
                b_sh_next = b_mux;
                bit_next  = '0;
                if (op_c.first)
                begin
                    acc_next = '0;
                end
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                acc_next  = acc_sum;
                a_sh_next = a_sh_reg << 1;
                b_sh_next = b_sh_reg >> 1;
                bit_next  = bit_reg + 1'b1;
                if (bit_reg == 6'(MUL_STEPS - 1))
                begin
                    case (op_c.dst)
                        DST_H0:  h_next[0] = acc_sum[H_W-1:0];
                        DST_H1:  h_next[1] = acc_sum[H_W-1:0];
                        DST_H2:  h_next[2] = acc_sum[H_W-1:0];
                        DST_Q0:  q_next[0] = acc_sum[Q_W-1:0];
                        DST_Q1:  q_next[1] = acc_sum[Q_W-1:0];
                        DST_Q2:  q_next[2] = acc_sum[Q_W-1:0];
                        DST_A:   a_next    = acc_sum[DOT_W-1:0];
                        DST_UN:  un_next   = acc_sum[DOT_W-1:0];
                        DST_VN:  vn_next   = acc_sum[DOT_W-1:0];
                        default: tn_next   = acc_sum[TN_W-1:0];
                    endcase
                    if (op_reg == 5'(NUM_OPS - 1))
                    begin
                        state_next = ST_NEG;
                    end
                    else
                    begin
                        op_next    = op_reg + 1'b1;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_NEG:
            begin
                // fold the determinant sign into the numerators
                if (a_reg[DOT_W-1])
                begin
                    absa_next = -AB_W'($signed(a_reg));
                    sun_next  = -AB_W'($signed(un_reg));
                    svn_next  = -AB_W'($signed(vn_reg));
                    stn_next  = -ST_W'($signed(tn_reg));
                end
                else
                begin
                    absa_next = AB_W'($signed(a_reg));
                    sun_next  = AB_W'($signed(un_reg));
                    svn_next  = AB_W'($signed(vn_reg));
                    stn_next  = ST_W'($signed(tn_reg));
                end
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                hit_next = !miss;
                if (miss)
                begin
                    state_next = ST_UPD;
                end
                else if (sat)
                begin
                    t_next     = DIST_MAX;
                    state_next = ST_UPD;
                end
                else
                begin
                    rem_next   = c_ts[TS_W-1:0];
                    den_next   = c_abs[TS_W-1:0] << (DIV_STEPS - 1);
                    quot_next  = '0;
                    div_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_ge)
                begin
                    rem_next = rem_reg - den_reg;
                end
                den_next  = den_reg >> 1;
                quot_next = quot_sh;
                div_next  = div_reg + 1'b1;
                if (div_reg == 5'(DIV_STEPS - 1))
                begin
                    t_next     = quot_sh;
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                if (hit_reg && (!seen_reg || (t_reg < best_dist_reg)))
                begin
                    best_dist_next = t_reg;
                    best_idx_next  = IDX_W'(cnt_reg);
                    seen_next      = 1'b1;
                end
                cnt_next   = (cnt_inc == CNT_LIMIT) ? '0 : cnt_inc[CNT_W-1:0];
                state_next = tri_reg.last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (!res_full)
                begin
                    res_push       = 1'b1;
                    seen_next      = 1'b0;
                    best_dist_next = DIST_MAX;
                    best_idx_next  = '0;
                    cnt_next       = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= '0;
            bit_reg       <= '0;
            div_reg       <= '0;
            seen_reg      <= 1'b0;
            best_dist_reg <= DIST_MAX;
            best_idx_reg  <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            bit_reg       <= bit_next;
            div_reg       <= div_next;
            seen_reg      <= seen_next;
            best_dist_reg <= best_dist_next;
            best_idx_reg  <= best_idx_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tri_reg  <= tri_next;
        a_sh_reg <= a_sh_next;
        b_sh_reg <= b_sh_next;
        acc_reg  <= acc_next;
        h_reg    <= h_next;
        q_reg    <= q_next;
        a_reg    <= a_next;
        un_reg   <= un_next;
        vn_reg   <= vn_next;
        tn_reg   <= tn_next;
        absa_reg <= absa_next;
        sun_reg  <= sun_next;
        svn_reg  <= svn_next;
        stn_reg  <= stn_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
        hit_reg  <= hit_next;
        t_reg    <= t_next;
    end

endmodule

/* rtl/nearest_ray_triangle_hit_unit.sv */
// throughput: the engine finishes one triangle before taking the next, held by the single serial multiplier
//   (24 products in sequence) and the 31-step divider
// triangles queue two deep ahead of the engine, results queue two deep behind it
// reset: asynchronous active low, clears queues and nearest hit state, ray registers to defaults
// ----------------------------------------------------------------------------
// nearest_ray_triangle_hit_unit
// nearest ray-triangle hit over a triangle stream for one configured ray
// ----------------------------------------------------------------------------
module nearest_ray_triangle_hit_unit
    import nrth_pkg::*;
#(
    parameter int MAX_TRIANGLES = DEF_MAX_TRIANGLES,
    parameter int TRI_DEPTH     = DEF_TRI_DEPTH,
    parameter int RES_DEPTH     = DEF_RES_DEPTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    push,
    output logic                    full,
    input  logic signed [VTX_W-1:0] v0_x,
    input  logic signed [VTX_W-1:0] v0_y,
    input  logic signed [VTX_W-1:0] v0_z,
    input  logic signed [VTX_W-1:0] v1_x,
    input  logic signed [VTX_W-1:0] v1_y,
    input  logic signed [VTX_W-1:0] v1_z,
    input  logic signed [VTX_W-1:0] v2_x,
    input  logic signed [VTX_W-1:0] v2_y,
    input  logic signed [VTX_W-1:0] v2_z,
    input  logic                    last_triangle,
    output logic                    empty,
    input  logic                    pop,
    output logic                    any_hit,
    output logic [DIST_W-1:0]       nearest_distance,
    output logic [IDX_W-1:0]        nearest_index
);

    logic signed [VTX_W-1:0] origin_x_reg;
    logic signed [VTX_W-1:0] origin_y_reg;
    logic signed [VTX_W-1:0] origin_z_reg;
    logic signed [D_W-1:0]   dir_x_reg;
    logic signed [D_W-1:0]   dir_y_reg;
    logic signed [D_W-1:0]   dir_z_reg;

    logic    tri_pop;
    logic    tri_empty;
    tri_t    tri_data;
    logic    res_push;
    logic    res_full;
    result_t res_data;
    logic [$bits(result_t)-1:0] res_rdata;
    result_t res_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
            dir_x_reg    <= '0;
            dir_y_reg    <= '0;
            dir_z_reg    <= DIR_Z_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ORIGIN_X: origin_x_reg <= cfg_data;
                REG_ORIGIN_Y: origin_y_reg <= cfg_data;
                REG_ORIGIN_Z: origin_z_reg <= cfg_data;
                REG_DIR_X:    dir_x_reg    <= cfg_data[D_W-1:0];
                REG_DIR_Y:    dir_y_reg    <= cfg_data[D_W-1:0];
                REG_DIR_Z:    dir_z_reg    <= cfg_data[D_W-1:0];
                default:      ;
            endcase
        end
    end

    nrth_front #(
        .QUEUE_DEPTH (TRI_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .v0_x          (v0_x),
        .v0_y          (v0_y),
        .v0_z          (v0_z),
        .v1_x          (v1_x),
        .v1_y          (v1_y),
        .v1_z          (v1_z),
        .v2_x          (v2_x),
        .v2_y          (v2_y),
        .v2_z          (v2_z),
        .last_triangle (last_triangle),
        .origin_x      (origin_x_reg),
        .origin_y      (origin_y_reg),
        .origin_z      (origin_z_reg),
        .tri_pop       (tri_pop),
        .tri_empty     (tri_empty),
        .tri_data      (tri_data)
    );

    nrth_back #(
        .MAX_TRIANGLES (MAX_TRIANGLES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .dir_x     (dir_x_reg),
        .dir_y     (dir_y_reg),
        .dir_z     (dir_z_reg),
        .tri_empty (tri_empty),
        .tri_data  (tri_data),
        .tri_pop   (tri_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_data)
    );

    nrth_queue #(
        .WIDTH ($bits(result_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_data),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign res_out          = result_t'(res_rdata);
    assign any_hit          = res_out.hit;
    assign nearest_distance = res_out.distance;
    assign nearest_index    = res_out.idx;

endmodule

/* rtl/nrth_checker.sv */
// ----------------------------------------------------------------------------
// nrth_checker
// port-level checks on the result side, bound to the top level
// ----------------------------------------------------------------------------
`include "nearest_ray_triangle_hit_unit_macros.svh"

module nrth_checker
    import nrth_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              empty,
    input logic              pop,
    input logic              any_hit,
    input logic [DIST_W-1:0] nearest_distance,
    input logic [IDX_W-1:0]  nearest_index
);

    // waiting result holds until its transfer
    `NRTH_ASSERT_NEXT(a_res_hold, !empty && !pop, $stable(nearest_distance) && $stable(nearest_index) && $stable(any_hit), "result changed while waiting")

    // a miss reports saturated distance and index zero
    `NRTH_ASSERT_IMPL(a_miss_fields, !empty && !any_hit, nearest_distance == DIST_MAX && nearest_index == '0, "miss result fields wrong")

    // a hit lies beyond one lsb so its distance is never zero
    `NRTH_ASSERT_IMPL(a_hit_nonzero, !empty && any_hit, nearest_distance != '0, "hit with zero distance")

endmodule

bind nearest_ray_triangle_hit_unit nrth_checker u_nrth_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench for nearest_ray_triangle_hit_unit
// streams triangle meshes against a configured ray and compares each mesh
// result with an exact 128-bit fixed point intersection predictor
// ----------------------------------------------------------------------------
module testbench;
    import nrth_pkg::*;

    typedef struct {
        logic signed [VTX_W-1:0] v[9];
        logic                    last;
    } triangle_t;

    typedef struct {
        logic              hit;
        logic [DIST_W-1:0] distance;
        logic [IDX_W-1:0]  idx;
    } nearest_t;

    localparam int DRAIN_CYCLES = 900;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]        cfg_data;
    logic                    push;
    logic                    full;
    logic signed [VTX_W-1:0] v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z;
    logic                    last_triangle;
    logic                    empty;
    logic                    pop;
    logic                    any_hit;
    logic [DIST_W-1:0]       nearest_distance;
    logic [IDX_W-1:0]        nearest_index;

    logic signed [VTX_W-1:0] ray_origin[3];
    logic signed [D_W-1:0]   ray_dir[3];
    logic [DIST_W-1:0]       best_dist;
    logic [IDX_W-1:0]        best_idx;
    logic                    best_seen;
    int                      tri_count;
    nearest_t                nearest_q[$];

    int mismatches;
    int burst_left;
    bit sender_idles;
    bit receiver_stalls;

    nearest_ray_triangle_hit_unit u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .push             (push),
        .full             (full),
        .v0_x             (v0_x),
        .v0_y             (v0_y),
        .v0_z             (v0_z),
        .v1_x             (v1_x),
        .v1_y             (v1_y),
        .v1_z             (v1_z),
        .v2_x             (v2_x),
        .v2_y             (v2_y),
        .v2_z             (v2_z),
        .last_triangle    (last_triangle),
        .empty            (empty),
        .pop              (pop),
        .any_hit          (any_hit),
        .nearest_distance (nearest_distance),
        .nearest_index    (nearest_index)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #150ms;
        $display("nearest_ray_triangle_hit_unit verification failed");
        $finish;
    end

    // moller-trumbore in exact 128-bit fixed point
    function automatic logic ray_hits(input triangle_t tri_item, output logic [DIST_W-1:0] t);
        logic signed [127:0] d[3], p0[3], e1[3], e2[3], s[3], h[3], q[3];
        logic signed [127:0] a, absa, un, vn, tn, ts, quo;
        logic                neg;
        t = '0;
        for (int i = 0; i < 3; i++)
        begin
            d[i]  = ray_dir[i];
            p0[i] = tri_item.v[i];
            e1[i] = tri_item.v[3+i] - p0[i];
            e2[i] = tri_item.v[6+i] - p0[i];
            s[i]  = ray_origin[i] - p0[i];
        end
        h[0] = d[1] * e2[2] - d[2] * e2[1];
        h[1] = d[2] * e2[0] - d[0] * e2[2];
        h[2] = d[0] * e2[1] - d[1] * e2[0];
        a    = e1[0] * h[0] + e1[1] * h[1] + e1[2] * h[2];
        neg  = a < 0;
        absa = neg ? -a : a;
        if (absa <= DET_EPS)
            return 1'b0;
        q[0] = s[1] * e1[2] - s[2] * e1[1];
        q[1] = s[2] * e1[0] - s[0] * e1[2];
        q[2] = s[0] * e1[1] - s[1] * e1[0];
        un = s[0] * h[0] + s[1] * h[1] + s[2] * h[2];
        vn = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
        tn = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
        if (neg)
        begin
            un = -un;
            vn = -vn;
            tn = -tn;
        end
        if (un < 0 || un > absa || vn < 0 || un + vn > absa)
            return 1'b0;
        ts = tn <<< 16;
        if (!(ts > absa))
            return 1'b0;
        quo = ts / absa;
        t = (quo > 128'sh7FFFFFFF) ? DIST_MAX : quo[DIST_W-1:0];
        return 1'b1;
    endfunction

    task automatic track_triangle(input triangle_t tri_item);
        logic [DIST_W-1:0] t;
        nearest_t          exp_item;
        if (ray_hits(tri_item, t) && (!best_seen || t < best_dist))
        begin
            best_dist = t;
            best_idx  = tri_count[IDX_W-1:0];
            best_seen = 1'b1;
        end
        tri_count = (tri_count + 1 >= DEF_MAX_TRIANGLES) ? 0 : tri_count + 1;
        if (tri_item.last)
        begin
            exp_item  = '{best_seen, best_dist, best_idx};
            nearest_q = {nearest_q, exp_item};
            best_dist = DIST_MAX;
            best_idx  = '0;
            best_seen = 1'b0;
            tri_count = 0;
        end
    endtask

    task automatic report_mismatch(input string what, input longint exp_v, input longint act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, what, exp_v, act_v);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && !empty && pop)
        begin
            if (nearest_q.size() == 0)
                report_mismatch("unexpected result transfer", 0, 1);
            else
            begin
                nearest_t e;
                e = nearest_q.pop_front();
                if (any_hit !== e.hit)
                    report_mismatch("any_hit", e.hit, any_hit);
                if (nearest_distance !== e.distance)
                    report_mismatch("nearest_distance", e.distance, nearest_distance);
                if (nearest_index !== e.idx)
                    report_mismatch("nearest_index", e.idx, nearest_index);
            end
        end
    end

    // receiver stall pattern
    always @(posedge clk)
    begin
        if (!receiver_stalls)
            pop <= 1'b1;
        else if ($urandom_range(0, 99) < 3)
            pop <= 1'b0;
        else if (!pop && $urandom_range(0, 9) < 8)
            pop <= 1'b0;
        else
            pop <= $urandom_range(0, 2) != 0;
    end

    task automatic send_triangle(input triangle_t tri_item);
        push          <= 1'b1;
        v0_x          <= tri_item.v[0];
        v0_y          <= tri_item.v[1];
        v0_z          <= tri_item.v[2];
        v1_x          <= tri_item.v[3];
        v1_y          <= tri_item.v[4];
        v1_z          <= tri_item.v[5];
        v2_x          <= tri_item.v[6];
        v2_y          <= tri_item.v[7];
        v2_z          <= tri_item.v[8];
        last_triangle <= tri_item.last;
        @(posedge clk);
        while (full)
            @(posedge clk);
        track_triangle(tri_item);
        if (!sender_idles)
            return;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 1200)) @(posedge clk);
            burst_left = $urandom_range(0, 6);
        end
    endtask

    task automatic wait_idle;
        push <= 1'b0;
        @(posedge clk);
        while (nearest_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_ray(input logic signed [31:0] ox, oy, oz, input logic signed [31:0] dx, dy, dz);
        logic [CFG_W-1:0] vals[6];
        vals = '{ox, oy, oz, dx, dy, dz};
        for (int i = 0; i < 6; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= i[CFG_IDX_W-1:0];
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        // indexes past the register list are ignored
        cfg_index <= REG_DIR_Z + 3'd1;
        cfg_data  <= $urandom;
        @(posedge clk);
        cfg_index <= REG_DIR_Z + 3'd2;
        cfg_data  <= $urandom;
        @(posedge clk);
        cfg_we <= 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            ray_origin[i] = vals[i];
            ray_dir[i]    = vals[3+i][D_W-1:0];
        end
    endtask

    function automatic triangle_t flat_triangle(input longint cx, cy, cz, input logic lst);
        triangle_t tri_item;
        tri_item.v = '{cx - 65536, cy - 65536, cz, cx + 131072, cy - 65536, cz,
                       cx - 65536, cy + 131072, cz};
        tri_item.last = lst;
        return tri_item;
    endfunction

    function automatic triangle_t aimed_triangle(input logic lst);
        triangle_t tri_item;
        longint    c[3];
        int        t_units, spread;
        t_units = $urandom_range(0, 200);
        spread  = $urandom_range(1, 262144);
        for (int i = 0; i < 3; i++)
            c[i] = longint'(ray_origin[i]) + longint'(ray_dir[i]) * t_units;
        for (int k = 0; k < 9; k++)
            tri_item.v[k] = c[k % 3] + $signed($urandom_range(0, 2 * spread)) - spread;
        tri_item.last = lst;
        return tri_item;
    endfunction

    function automatic triangle_t noise_triangle(input logic lst);
        triangle_t tri_item;
        for (int k = 0; k < 9; k++)
            tri_item.v[k] = $urandom;
        tri_item.last = lst;
        return tri_item;
    endfunction

    task automatic send_meshes(input int n_items);
        int sent, len;
        sent = 0;
        while (sent < n_items)
        begin
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_triangle(noise_triangle(k == len - 1));
                else
                    send_triangle(aimed_triangle(k == len - 1));
            end
            sent += len;
        end
    endtask

    task automatic test_default_ray;
        triangle_t tri_item;
        send_triangle(flat_triangle(0, 0, -5 * 65536, 1'b0));
        send_triangle(flat_triangle(0, 0, -3 * 65536, 1'b0));
        send_triangle(flat_triangle(0, 0, -3 * 65536, 1'b0));
        send_triangle(flat_triangle(10 * 65536, 0, -2 * 65536, 1'b0));
        tri_item = flat_triangle(0, 0, -65536, 1'b0);
        tri_item.v[3] = tri_item.v[6];
        tri_item.v[4] = tri_item.v[7];
        tri_item.v[5] = tri_item.v[8];
        tri_item.v[6] = 131072;
        tri_item.v[7] = -65536;
        tri_item.v[8] = -65536;
        send_triangle(tri_item);
        tri_item.v = '{-65536, 0, 0, 65536, 0, -65536, 0, 0, -131072};
        send_triangle(tri_item);
        send_triangle(flat_triangle(0, 0, 2 * 65536, 1'b0));
        send_triangle(flat_triangle(0, 0, 0, 1'b0));
        send_triangle(flat_triangle(0, 0, -4 * 65536, 1'b1));
        send_triangle(flat_triangle(0, 0, 1, 1'b1));
        send_triangle(flat_triangle(0, 0, -1, 1'b1));
        tri_item.v = '{-65536, -65536, 32'sh80000000, 131072, -65536, 32'sh80000000,
                       -65536, 131072, 32'sh80000000};
        tri_item.last = 1'b0;
        send_triangle(tri_item);
        send_triangle(tri_item);
        tri_item.v = '{default: 32'sh7FFFFFFF};
        send_triangle(tri_item);
        tri_item.v = '{default: 32'sh80000000};
        send_triangle(tri_item);
        tri_item.v = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF,
                       32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
                       32'sh7FFFFFFF};
        tri_item.last = 1'b1;
        send_triangle(tri_item);
        wait_idle();
    endtask

    task automatic test_ray_extremes;
        set_ray(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 65536, 0, 0);
        send_meshes(6);
        wait_idle();
        set_ray(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 0, -65536, 0);
        send_meshes(6);
        wait_idle();
        set_ray(0, 0, 0, 0, 0, 0);
        send_meshes(4);
        wait_idle();
        set_ray(65536, -65536, 32768, -65536, 0, 0);
        send_triangle(flat_triangle(0, 0, 0, 1'b0));
        send_meshes(6);
        wait_idle();
    endtask

    task automatic test_random_rays;
        int sx, sy;
        for (int phase = 0; phase < 8; phase++)
        begin
            sender_idles    = phase != 3;
            receiver_stalls = phase != 5;
            sx = $urandom_range(0, 2) == 0 ? 0 : 46341;
            sy = $urandom_range(0, 1) ? 46341 : -46341;
            case (phase % 4)
                0: set_ray($signed($urandom) >>> 8, $signed($urandom) >>> 8,
                           $signed($urandom) >>> 8, 0, 0, 65536);
                1: set_ray($signed($urandom) >>> 8, $signed($urandom) >>> 8,
                           $signed($urandom) >>> 8, sx, sy, 0);
                2: set_ray($signed($urandom) >>> 8, 0, $signed($urandom) >>> 8,
                           37837, -37837, 37837);
                default: set_ray($signed($urandom) >>> 8, $signed($urandom) >>> 8,
                                 $signed($urandom) >>> 8,
                                 $signed($urandom_range(0, 131072)) - 65536,
                                 $signed($urandom_range(0, 131072)) - 65536,
                                 $signed($urandom_range(0, 131072)) - 65536);
            endcase
            send_meshes(100);
            wait_idle();
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        push            = 1'b0;
        {v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z} = '0;
        last_triangle   = 1'b0;
        mismatches      = 0;
        burst_left      = 0;
        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
        ray_origin      = '{0, 0, 0};
        ray_dir         = '{0, 0, DIR_Z_RESET};
        best_dist       = DIST_MAX;
        best_idx        = '0;
        best_seen       = 1'b0;
        tri_count       = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_ray();
        test_ray_extremes();
        test_random_rays();

        if (mismatches == 0 && nearest_q.size() == 0)
            $display("nearest_ray_triangle_hit_unit verification clean");
        else
            $display("nearest_ray_triangle_hit_unit verification failed");
        $finish;
    end

endmodule
